/* hw/rtl/mf3_pkg.sv */
package mf3_pkg;

    // Frame limits and the widths that follow from them.
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 4096;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = COL_W + 1;
    localparam int HGT_W = ROW_W + 1;

    // Register field widths and reset values.
    localparam int LW_BITS    = 11;
    localparam int FH_BITS    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int unsigned LINE_WIDTH_RST   = 640;
    localparam int unsigned FRAME_HEIGHT_RST = 480;

    localparam int PIX_W = 8;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [WID_W-1:0] wid_t;
    typedef logic [HGT_W-1:0] hgt_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    // Control word of an item after it has been accepted.
    typedef struct packed {
        logic valid_pix;   // pixel item: shifts the window, updates the line stores
        logic emit;        // the item produces a result
        logic from_store;  // result value is read back from a line store
        logic sel_lower;   // store read-back takes the lower store
        logic interior;    // result is a median, not a pass-through
        logic last;        // result closes the frame
        logic fwd;         // upper-store read is replaced by the pending write
        col_t col;
        pix_t pix;
    } stage_t;

    typedef struct packed {
        pix_t lo;
        pix_t mid;
        pix_t hi;
    } tri_t;

    function automatic wid_t clamp_width(logic [LW_BITS-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0)
        begin
            x = 32'd1;
        end
        else if (x > MAX_WIDTH)
        begin
            x = 32'(MAX_WIDTH);
        end
        return x[WID_W-1:0];
    endfunction

    function automatic hgt_t clamp_height(logic [FH_BITS-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0)
        begin
            x = 32'd1;
        end
        else if (x > MAX_HEIGHT)
        begin
            x = 32'(MAX_HEIGHT);
        end
        return x[HGT_W-1:0];
    endfunction

    function automatic pix_t max2(pix_t a, pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t min2(pix_t a, pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic tri_t sort3(pix_t a, pix_t b, pix_t c);
        pix_t l1;
        pix_t h1;
        pix_t h2;
        tri_t r;
        l1 = min2(a, b);
        h1 = max2(a, b);
        h2 = max2(h1, c);
        r.hi  = h2;
        r.lo  = min2(l1, min2(h1, c));
        r.mid = max2(l1, min2(h1, c));
        return r;
    endfunction

    function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
        return max2(max2(a, b), c);
    endfunction

    function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
        return min2(min2(a, b), c);
    endfunction

    function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

/* hw/rtl/mf3_if.sv */
interface mf3_req_if;
    import mf3_pkg::*;
    logic valid;
    logic ready;
    logic req_type;
    pix_t pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

interface mf3_res_if;
    import mf3_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel_out;
    logic frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface mf3_cfg_if;
    import mf3_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/median_filter_3x3.sv */
// Channel  Dir  Handshake      Payload
// cfg      in   valid / ready  index (0 line_width, 1 frame_height), data
// req      in   valid / ready  req_type (0 pixel, 1 flush), pixel_in
// res      out  valid / ready  pixel_out, frame_last
//
// One item is accepted per clock while res is not stalled; the result that it causes
// passes the store read, window and three sorting-network stages before it leaves.
// Reset clears the frame position, the window and all stage valids; the line
// stores hold garbage until the first frame rows have written them.
// A stall on res freezes the whole pipeline, and req.ready follows at once.
module median_filter_3x3 (
    input  logic        clk,
    input  logic        rst_n,
    mf3_cfg_if.sink     cfg,
    mf3_req_if.sink     req,
    mf3_res_if.source   res
);
    import mf3_pkg::*;

    // The pipeline moves as one whenever the output register is empty or
    // being drained, so an item is taken in the same cycle as the previous
    // result leaves.
    logic   adv;
    logic   acc;
    col_t   rd_addr;
    stage_t b;
    pix_t   up_rd;
    pix_t   lo_rd;
    pix_t   up_val;
    pix_t   fwd_data_reg;
    logic   res_valid;

    assign adv       = !res_valid || res.ready;
    assign acc       = req.valid && adv;
    assign req.ready = adv;

    mf3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .acc      (acc),
        .adv      (adv),
        .req_type (req.req_type),
        .pixel    (req.pixel_in),
        .rd_addr  (rd_addr),
        .b        (b)
    );

    // The lower store takes the new pixel as soon as the item is accepted. The
    // upper store takes the old lower value once it has been read, when the pipeline advances.
    mf3_line_ram u_lower (
        .clk   (clk),
        .we    (acc && (req.req_type == REQ_PIXEL)),
        .waddr (rd_addr),
        .wdata (req.pixel_in),
        .re    (acc),
        .raddr (rd_addr),
        .rdata (lo_rd)
    );

    mf3_line_ram u_upper (
        .clk   (clk),
        .we    (adv && b.valid_pix),
        .waddr (b.col),
        .wdata (lo_rd),
        .re    (acc),
        .raddr (rd_addr),
        .rdata (up_rd)
    );

    // When a read of the upper store hits the column whose write is still in
    // flight (one-pixel rows, or the first flush after the last pixel), the
    // value being written is kept here and replaces the stale read.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fwd_data_reg <= lo_rd;
        end
    end

    assign up_val = b.fwd ? fwd_data_reg : up_rd;

    mf3_median u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .b          (b),
        .up_val     (up_val),
        .lo_val     (lo_rd),
        .res_valid  (res_valid),
        .pixel_out  (res.pixel_out),
        .frame_last (res.frame_last)
    );

    assign res.valid = res_valid;

    // A read that collides with the pending upper-store write must be forwarded.
    a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && b.valid_pix && (b.col == rd_addr)) |=> b.fwd)
        else $error("upper store collision not forwarded");

    // Results drained from the line stores all lie on the frame border.
    a_store_is_border: assert property (@(posedge clk) disable iff (!rst_n)
        b.from_store |-> (b.emit && !b.interior))
        else $error("store read-back marked as interior result");

    // Only a flush can close a frame, since results trail their pixels.
    a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (b.emit && b.last) |-> b.from_store)
        else $error("frame end produced by a pixel item");

endmodule

/* hw/rtl/mf3_line_ram.sv */
module mf3_line_ram (
    input  logic          clk,
    input  logic          we,
    input  mf3_pkg::col_t waddr,
    input  mf3_pkg::pix_t wdata,
    input  logic          re,
    input  mf3_pkg::col_t raddr,
    output mf3_pkg::pix_t rdata
);
    import mf3_pkg::*;

    pix_t mem [MAX_WIDTH];
    pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/mf3_ctrl.sv */
module mf3_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    mf3_cfg_if.sink          cfg,
    input  logic             acc,
    input  logic             adv,
    input  logic             req_type,
    input  mf3_pkg::pix_t    pixel,
    output mf3_pkg::col_t    rd_addr,
    output mf3_pkg::stage_t  b
);
    import mf3_pkg::*;

    wid_t   width_reg, width_next;
    hgt_t   height_reg, height_next;
    col_t   in_col_reg, in_col_next;
    row_t   in_row_reg, in_row_next;
    col_t   out_col_reg, out_col_next;
    row_t   out_row_reg, out_row_next;
    logic   done_reg, done_next;
    stage_t b_reg;
    stage_t item;

    logic flush;
    logic frame_start;
    col_t oc;
    row_t orow;
    logic in_col_end;
    logic in_row_end;
    logic out_col_end;
    logic out_row_end;
    logic pix_emit;
    logic interior;
    logic last;
    logic cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_comb
    begin
        flush       = (req_type == REQ_FLUSH);
        frame_start = !flush && (in_col_reg == '0) && (in_row_reg == '0);
        oc          = frame_start ? '0 : out_col_reg;
        orow        = frame_start ? '0 : out_row_reg;
        rd_addr     = flush ? out_col_reg : in_col_reg;

        in_col_end  = ({1'b0, in_col_reg} + WID_W'(1)) >= width_reg;
        in_row_end  = ({1'b0, in_row_reg} + HGT_W'(1)) >= height_reg;
        out_col_end = ({1'b0, oc} + WID_W'(1)) >= width_reg;
        out_row_end = ({1'b0, orow} + HGT_W'(1)) >= height_reg;

        // A pixel yields a result once one line plus one pixel is buffered.
        pix_emit = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        interior = (orow != '0) && (({1'b0, orow} + HGT_W'(2)) <= height_reg)
                   && (oc != '0) && (({1'b0, oc} + WID_W'(2)) <= width_reg);
        last     = out_row_end && out_col_end;

        item      = '0;
        item.col  = in_col_reg;
        item.pix  = pixel;
        item.fwd  = b_reg.valid_pix && (b_reg.col == rd_addr);

        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        done_next    = done_reg;

        if (acc)
        begin
            if (!flush)
            begin
                item.valid_pix = 1'b1;
                item.emit      = pix_emit;
                item.interior  = interior;
                item.last      = last;
                if (in_col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_end ? '0 : in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                done_next    = in_col_end && in_row_end;
                out_col_next = oc;
                out_row_next = orow;
            end
            else if (done_reg)
            begin
                item.emit       = 1'b1;
                item.from_store = 1'b1;
                item.sel_lower  = out_row_end;
                item.last       = last;
                if (last)
                begin
                    done_next = 1'b0;
                end
            end

            if (item.emit)
            begin
                if (last)
                begin
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = orow + ROW_W'(1);
                end
                else
                begin
                    out_col_next = oc + COL_W'(1);
                    out_row_next = orow;
                end
            end
        end

        if (cfg_wr)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_LINE_WIDTH:
                begin
                    width_next   = clamp_width(cfg.data[LW_BITS-1:0]);
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    done_next    = 1'b0;
                end
                CFG_FRAME_HEIGHT:
                begin
                    height_next  = clamp_height(cfg.data[FH_BITS-1:0]);
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    done_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= clamp_width(LW_BITS'(LINE_WIDTH_RST));
            height_reg  <= clamp_height(FH_BITS'(FRAME_HEIGHT_RST));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg    <= 1'b0;
            b_reg       <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            done_reg    <= done_next;
            if (adv)
            begin
                b_reg <= acc ? item : '0;
            end
        end
    end

    assign b = b_reg;

endmodule

/* hw/rtl/mf3_median.sv */
module mf3_median (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  mf3_pkg::stage_t b,
    input  mf3_pkg::pix_t   up_val,
    input  mf3_pkg::pix_t   lo_val,
    output logic            res_valid,
    output mf3_pkg::pix_t   pixel_out,
    output logic            frame_last
);
    import mf3_pkg::*;

    pix_t win_reg [9];

    logic c_valid_reg;
    logic c_int_reg;
    logic c_last_reg;
    logic c_store_reg;
    pix_t c_sval_reg;

    logic m1_valid_reg;
    logic m1_int_reg;
    logic m1_last_reg;
    pix_t m1_pass_reg;
    tri_t m1_col_reg [3];

    logic m2_valid_reg;
    logic m2_int_reg;
    logic m2_last_reg;
    pix_t m2_pass_reg;
    pix_t m2_maxlo_reg;
    pix_t m2_medmid_reg;
    pix_t m2_minhi_reg;

    logic o_valid_reg;
    logic o_last_reg;
    pix_t o_pix_reg;

    // Window and stage-valid state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            c_valid_reg  <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (b.valid_pix)
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= up_val;
                win_reg[3] <= win_reg[4];
                win_reg[4] <= win_reg[5];
                win_reg[5] <= lo_val;
                win_reg[6] <= win_reg[7];
                win_reg[7] <= win_reg[8];
                win_reg[8] <= b.pix;
            end
            c_valid_reg  <= b.emit;
            m1_valid_reg <= c_valid_reg;
            m2_valid_reg <= m1_valid_reg;
            o_valid_reg  <= m2_valid_reg;
        end
    end

    // Sorting network payload: column sort, then max/median/min, then median of three.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_int_reg   <= b.interior;
            c_last_reg  <= b.last;
            c_store_reg <= b.from_store;
            c_sval_reg  <= b.sel_lower ? lo_val : up_val;

            m1_int_reg  <= c_int_reg;
            m1_last_reg <= c_last_reg;
            m1_pass_reg <= c_store_reg ? c_sval_reg : win_reg[4];
            for (int k = 0; k < 3; k++)
            begin
                m1_col_reg[k] <= sort3(win_reg[k], win_reg[k+3], win_reg[k+6]);
            end

            m2_int_reg    <= m1_int_reg;
            m2_last_reg   <= m1_last_reg;
            m2_pass_reg   <= m1_pass_reg;
            m2_maxlo_reg  <= max3(m1_col_reg[0].lo, m1_col_reg[1].lo, m1_col_reg[2].lo);
            m2_medmid_reg <= med3(m1_col_reg[0].mid, m1_col_reg[1].mid, m1_col_reg[2].mid);
            m2_minhi_reg  <= min3(m1_col_reg[0].hi, m1_col_reg[1].hi, m1_col_reg[2].hi);

            o_last_reg <= m2_last_reg;
            o_pix_reg  <= m2_int_reg ? med3(m2_maxlo_reg, m2_medmid_reg, m2_minhi_reg)
                                     : m2_pass_reg;
        end
    end

    assign res_valid  = o_valid_reg;
    assign pixel_out  = o_pix_reg;
    assign frame_last = o_last_reg;

endmodule
